[src/ddc_pkg.sv]
package ddc_pkg;

    // event kinds
    localparam logic [1:0] KIND_PACKET     = 2'd0;
    localparam logic [1:0] KIND_TRAY_EDGE  = 2'd1;
    localparam logic [1:0] KIND_FRONT_HIT  = 2'd2;
    localparam logic [1:0] KIND_BACK_HIT   = 2'd3;

    // packet types and sub-commands
    localparam logic [7:0] PTYPE_READ      = 8'h01;
    localparam logic [7:0] PTYPE_WRITE     = 8'h02;
    localparam logic [7:0] SUB_STATUS      = 8'h01;
    localparam logic [7:0] SUB_DISPENSE    = 8'h01;
    localparam logic [7:0] SUB_RETRACT     = 8'h02;
    localparam logic [7:0] SUB_CHANGE_ID   = 8'h04;
    localparam logic [7:0] SUB_LED         = 8'h05;
    localparam logic [7:0] LED_OFF         = 8'h00;
    localparam logic [7:0] LED_ON          = 8'h01;
    localparam logic [7:0] LED_TOGGLE      = 8'h02;

    // status flags
    localparam logic [7:0] ST_STANDBY      = 8'h01;
    localparam logic [7:0] ST_DISPENSING   = 8'h02;
    localparam logic [7:0] ST_RETRACTING   = 8'h04;
    localparam logic [7:0] ST_OPEN         = 8'h08;
    localparam logic [7:0] ST_CLOSED       = 8'h10;
    localparam logic [7:0] ST_FILLED       = 8'h20;
    localparam logic [7:0] ST_EMPTY        = 8'h40;

    // reply framing
    localparam logic [7:0] SYNC_BYTE       = 8'hFF;
    localparam logic [7:0] REPLY_LEN       = 8'h02;
    localparam logic [7:0] ID_RESET        = 8'hFE;
    localparam logic [7:0] STATUS_RESET    = ST_STANDBY | ST_CLOSED;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] packet_id;
        logic [7:0] packet_type;
        logic [7:0] payload_size;
        logic [7:0] payload_first;
        logic [7:0] payload_second;
    } item_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] dev_id;
        logic       bridge_a;
        logic       bridge_b;
        logic       led;
    } state_t;

    localparam state_t STATE_RESET = '{
        status:   STATUS_RESET,
        dev_id:   ID_RESET,
        bridge_a: 1'b1,
        bridge_b: 1'b1,
        led:      1'b0
    };

endpackage

[src/ddc_in_if.sv]
interface ddc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] packet_id;
    logic [7:0] packet_type;
    logic [7:0] payload_size;
    logic [7:0] payload_first;
    logic [7:0] payload_second;

    modport source (
        output valid, kind, packet_id, packet_type, payload_size,
               payload_first, payload_second,
        input  ready
    );

    modport sink (
        input  valid, kind, packet_id, packet_type, payload_size,
               payload_first, payload_second,
        output ready
    );
endinterface

[src/ddc_out_if.sv]
interface ddc_out_if;
    logic       valid;
    logic       ready;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       last;
    logic [7:0] status_now;
    logic       motor_a;
    logic       motor_b;
    logic       led_on;
    logic [7:0] current_id;

    modport source (
        output valid, reply_valid, reply_byte, last, status_now, motor_a,
               motor_b, led_on, current_id,
        input  ready
    );

    modport sink (
        input  valid, reply_valid, reply_byte, last, status_now, motor_a,
               motor_b, led_on, current_id,
        output ready
    );
endinterface

[src/ddc_step.sv]
module ddc_step (
    input  ddc_pkg::item_t  item,
    input  ddc_pkg::state_t cur,
    output ddc_pkg::state_t nxt,
    output logic            is_read
);
    import ddc_pkg::*;

    logic addressed;
    logic has_second;

    assign addressed  = (item.packet_id == cur.dev_id) && (item.payload_size != 8'd0);
    assign has_second = (item.payload_size >= 8'd2);

    always_comb
    begin
        nxt     = cur;
        is_read = 1'b0;
        case (item.kind)
            KIND_TRAY_EDGE:
            begin
                if (cur.status == (ST_STANDBY | ST_CLOSED))
                    nxt.status = ST_STANDBY | ST_CLOSED | ST_FILLED;
                else if (cur.status == (ST_STANDBY | ST_OPEN))
                    nxt.status = ST_STANDBY | ST_OPEN | ST_EMPTY;
            end
            KIND_FRONT_HIT:
            begin
                if (cur.status == ST_DISPENSING)
                begin
                    nxt.status   = ST_STANDBY | ST_OPEN;
                    nxt.bridge_a = 1'b1;
                    nxt.bridge_b = 1'b1;
                end
            end
            KIND_BACK_HIT:
            begin
                if (cur.status == ST_RETRACTING)
                begin
                    nxt.status   = ST_STANDBY | ST_CLOSED;
                    nxt.bridge_a = 1'b1;
                    nxt.bridge_b = 1'b1;
                end
            end
            default:
            begin
                if (addressed && item.packet_type == PTYPE_READ
                        && item.payload_first == SUB_STATUS)
                    is_read = 1'b1;
                else if (addressed && item.packet_type == PTYPE_WRITE)
                begin
                    case (item.payload_first)
                        SUB_DISPENSE:
                        begin
                            if (cur.status == (ST_STANDBY | ST_CLOSED | ST_FILLED))
                            begin
                                nxt.status   = ST_DISPENSING;
                                nxt.bridge_a = 1'b0;
                                nxt.bridge_b = 1'b1;
                            end
                        end
                        SUB_RETRACT:
                        begin
                            if (cur.status == (ST_STANDBY | ST_OPEN | ST_EMPTY))
                            begin
                                nxt.status   = ST_RETRACTING;
                                nxt.bridge_a = 1'b1;
                                nxt.bridge_b = 1'b0;
                            end
                        end
                        SUB_CHANGE_ID:
                        begin
                            if (has_second)
                                nxt.dev_id = item.payload_second;
                        end
                        SUB_LED:
                        begin
                            if (has_second)
                            begin
                                case (item.payload_second)
                                    LED_OFF:    nxt.led = 1'b0;
                                    LED_ON:     nxt.led = 1'b1;
                                    LED_TOGGLE: nxt.led = ~cur.led;
                                    default:    nxt.led = cur.led;
                                endcase
                            end
                        end
                        default:
                        begin
                            nxt = cur;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

[src/dispense_drawer_controller_top.sv]
// An event enters the input register when accepted and moves on to the result register
// once that is empty or its last beat is taken. Throughput: one event per cycle while
// results are taken; a status read holds the result register for six reply bytes, one
// per cycle while the receiver is ready, while the next event waits in the input register.
// Reset: status 0x11, id 0xFE, motor braked, LED off, both registers empty.
module dispense_drawer_controller_top (
    input  logic      clk,
    input  logic      rst_n,
    ddc_in_if.sink    events,
    ddc_out_if.source results
);
    import ddc_pkg::*;

    localparam logic [2:0] BEAT_SYNC1  = 3'd1;
    localparam logic [2:0] BEAT_ID     = 3'd2;
    localparam logic [2:0] BEAT_LEN    = 3'd3;
    localparam logic [2:0] BEAT_STATUS = 3'd4;
    localparam logic [2:0] BEAT_LAST   = 3'd5;

    item_t      item_reg;
    logic       in_valid_reg, in_valid_next;
    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       reply_reg, reply_next;
    logic [2:0] beat_reg, beat_next;

    state_t     step_state;
    logic       step_read;
    logic       in_fire, out_fire, final_take, advance, last_beat;
    logic [7:0] checksum;

    ddc_step u_step (
        .item    (item_reg),
        .cur     (state_reg),
        .nxt     (step_state),
        .is_read (step_read)
    );

    assign last_beat  = !reply_reg || (beat_reg == BEAT_LAST);
    assign out_fire   = out_valid_reg && results.ready;
    assign final_take = out_fire && last_beat;
    assign advance    = in_valid_reg && (!out_valid_reg || final_take);
    assign in_fire    = events.valid && events.ready;

    assign events.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        reply_next     = reply_reg;
        beat_next      = beat_reg;
        if (advance)
        begin
            state_next     = step_state;
            out_valid_next = 1'b1;
            reply_next     = step_read;
            beat_next      = '0;
        end
        else if (final_take)
            out_valid_next = 1'b0;
        else if (out_fire)
            beat_next = beat_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
            reply_reg     <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            reply_reg     <= reply_next;
            beat_reg      <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.kind           <= events.kind;
            item_reg.packet_id      <= events.packet_id;
            item_reg.packet_type    <= events.packet_type;
            item_reg.payload_size   <= events.payload_size;
            item_reg.payload_first  <= events.payload_first;
            item_reg.payload_second <= events.payload_second;
        end
    end

    // a status read leaves the state alone, so reply fields come straight from it
    assign checksum = ~(state_reg.dev_id + REPLY_LEN + state_reg.status);

    always_comb
    begin
        results.reply_byte = 8'h00;
        if (reply_reg)
        begin
            case (beat_reg)
                BEAT_SYNC1:  results.reply_byte = SYNC_BYTE;
                BEAT_ID:     results.reply_byte = state_reg.dev_id;
                BEAT_LEN:    results.reply_byte = REPLY_LEN;
                BEAT_STATUS: results.reply_byte = state_reg.status;
                BEAT_LAST:   results.reply_byte = checksum;
                default:     results.reply_byte = SYNC_BYTE;
            endcase
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.reply_valid = reply_reg;
    assign results.last        = last_beat;
    assign results.status_now  = state_reg.status;
    assign results.motor_a     = state_reg.bridge_a;
    assign results.motor_b     = state_reg.bridge_b;
    assign results.led_on      = state_reg.led;
    assign results.current_id  = state_reg.dev_id;

`ifndef SYNTHESIS
    a_beat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && reply_reg) |-> (beat_reg <= BEAT_LAST))
        else $error("reply beat past checksum");

    a_standby_braked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.status[0] |-> (state_reg.bridge_a && state_reg.bridge_b))
        else $error("motor driven while in standby");

    a_dispense_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.status == ST_DISPENSING) |-> (!state_reg.bridge_a && state_reg.bridge_b))
        else $error("wrong bridge drive while dispensing");

    a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_read) |=> $stable(state_reg))
        else $error("status read changed state");
`endif

endmodule

[tb/tb_dispense_drawer_controller_top.sv]
`timescale 1ns / 1ps

module tb_dispense_drawer_controller_top;
    import ddc_pkg::*;

    localparam int RANDOM_EVENTS = 393;
    localparam int HOLD_OFF      = 250;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [7:0] SUB_UNLOCK    = 8'h03;
    localparam logic [7:0] S_IDLE_CLOSED = ST_STANDBY | ST_CLOSED;
    localparam logic [7:0] S_LOADED      = ST_STANDBY | ST_CLOSED | ST_FILLED;
    localparam logic [7:0] S_IDLE_OPEN   = ST_STANDBY | ST_OPEN;
    localparam logic [7:0] S_EMPTY_OPEN  = ST_STANDBY | ST_OPEN | ST_EMPTY;

    typedef struct packed {
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       last;
        logic [7:0] status_now;
        logic       motor_a;
        logic       motor_b;
        logic       led_on;
        logic [7:0] current_id;
    } beat_t;

    typedef struct packed {
        item_t  it;
        logic   typed;
        state_t want;
    } row_t;

    logic clk;
    logic rst_n;

    ddc_in_if  event_ch ();
    ddc_out_if result_ch ();

    dispense_drawer_controller_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (event_ch),
        .results (result_ch)
    );

    state_t drawer;
    beat_t  step_beats [6];
    beat_t  pending_beats [$];
    row_t   directed [27];
    int     failures;
    int     burst_left;
    int     cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Drawer behavior: updates the drawer state and fills step_beats,
    // returns the number of result beats the event produces.
    function automatic int drawer_step(input item_t it, output bit acted);
        state_t     prior;
        logic [7:0] frame [6];
        int         k;
        prior = drawer;
        acted = 1'b0;
        case (it.kind)
            KIND_TRAY_EDGE:
            begin
                if (drawer.status == S_IDLE_CLOSED)
                    drawer.status = S_LOADED;
                else if (drawer.status == S_IDLE_OPEN)
                    drawer.status = S_EMPTY_OPEN;
            end
            KIND_FRONT_HIT:
            begin
                if (drawer.status == ST_DISPENSING)
                begin
                    drawer.bridge_a = 1'b1;
                    drawer.bridge_b = 1'b1;
                    drawer.status   = S_IDLE_OPEN;
                end
            end
            KIND_BACK_HIT:
            begin
                if (drawer.status == ST_RETRACTING)
                begin
                    drawer.bridge_a = 1'b1;
                    drawer.bridge_b = 1'b1;
                    drawer.status   = S_IDLE_CLOSED;
                end
            end
            default:
            begin
                if (it.packet_id == drawer.dev_id && it.payload_size != 8'd0)
                begin
                    if (it.packet_type == PTYPE_READ && it.payload_first == SUB_STATUS)
                    begin
                        frame[0] = SYNC_BYTE;
                        frame[1] = SYNC_BYTE;
                        frame[2] = drawer.dev_id;
                        frame[3] = REPLY_LEN;
                        frame[4] = drawer.status;
                        frame[5] = ~(drawer.dev_id + REPLY_LEN + drawer.status);
                        for (k = 0; k < 6; k++)
                            step_beats[k] = '{1'b1, frame[k], k == 5, drawer.status,
                                              drawer.bridge_a, drawer.bridge_b,
                                              drawer.led, drawer.dev_id};
                        acted = 1'b1;
                        return 6;
                    end
                    if (it.packet_type == PTYPE_WRITE)
                    begin
                        case (it.payload_first)
                            SUB_DISPENSE:
                            begin
                                if (drawer.status == S_LOADED)
                                begin
                                    drawer.status   = ST_DISPENSING;
                                    drawer.bridge_a = 1'b0;
                                    drawer.bridge_b = 1'b1;
                                end
                            end
                            SUB_RETRACT:
                            begin
                                if (drawer.status == S_EMPTY_OPEN)
                                begin
                                    drawer.status   = ST_RETRACTING;
                                    drawer.bridge_a = 1'b1;
                                    drawer.bridge_b = 1'b0;
                                end
                            end
                            SUB_CHANGE_ID:
                            begin
                                if (it.payload_size >= 8'd2)
                                    drawer.dev_id = it.payload_second;
                            end
                            SUB_LED:
                            begin
                                if (it.payload_size >= 8'd2)
                                begin
                                    case (it.payload_second)
                                        LED_OFF:    drawer.led = 1'b0;
                                        LED_ON:     drawer.led = 1'b1;
                                        LED_TOGGLE: drawer.led = ~drawer.led;
                                        default:    ;
                                    endcase
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        endcase
        acted = (drawer != prior);
        step_beats[0] = '{1'b0, 8'h00, 1'b1, drawer.status, drawer.bridge_a,
                          drawer.bridge_b, drawer.led, drawer.dev_id};
        return 1;
    endfunction

    // Runs the drawer model and queues what the block must return; a typed row
    // supplies its own single-beat expectation.
    function automatic bit queue_expected(input item_t it, input bit typed, input state_t want);
        bit    acted;
        int    n;
        int    k;
        beat_t b;
        n = drawer_step(it, acted);
        if (typed)
        begin
            b = '{1'b0, 8'h00, 1'b1, want.status, want.bridge_a, want.bridge_b,
                  want.led, want.dev_id};
            pending_beats.push_back(b);
        end
        else
        begin
            for (k = 0; k < n; k++)
                pending_beats.push_back(step_beats[k]);
        end
        return acted;
    endfunction

    function automatic row_t row(input logic [1:0] kind, input logic [7:0] pid, ptype, psize,
                                 p0, p1, input logic typed, input logic [7:0] st, id,
                                 input logic a, b, led);
        row_t r;
        r.it   = '{kind, pid, ptype, psize, p0, p1};
        r.typed = typed;
        r.want = '{st, id, a, b, led};
        return r;
    endfunction

    // Mostly walks the drawer through its load/dispense/retract cycle with
    // random content; the remainder is status reads, LED, id changes and noise.
    function automatic item_t random_event();
        item_t       it;
        logic [63:0] noise;
        int          pick;
        noise = {$urandom, $urandom};
        it    = noise[41:0];
        pick  = $urandom_range(0, 99);
        if (pick < 90)
        begin
            it.kind      = KIND_PACKET;
            it.packet_id = drawer.dev_id;
            it.payload_size = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'($urandom_range(1, 2));
        end
        if (pick < 55)
        begin
            case (drawer.status)
                S_LOADED:
                begin
                    it.packet_type   = PTYPE_WRITE;
                    it.payload_first = SUB_DISPENSE;
                end
                S_EMPTY_OPEN:
                begin
                    it.packet_type   = PTYPE_WRITE;
                    it.payload_first = SUB_RETRACT;
                end
                ST_DISPENSING: it.kind = KIND_FRONT_HIT;
                ST_RETRACTING: it.kind = KIND_BACK_HIT;
                default:       it.kind = KIND_TRAY_EDGE;
            endcase
        end
        else if (pick < 70)
        begin
            it.packet_type   = PTYPE_READ;
            it.payload_first = SUB_STATUS;
        end
        else if (pick < 82)
        begin
            it.packet_type   = PTYPE_WRITE;
            it.payload_first = SUB_LED;
            if ($urandom_range(0, 4) != 0)
                it.payload_second = 8'($urandom_range(0, 2));
        end
        else if (pick < 86)
        begin
            it.packet_type   = PTYPE_WRITE;
            it.payload_first = SUB_CHANGE_ID;
        end
        else if (pick < 90)
        begin
            it.packet_type   = 8'($urandom_range(0, 3));
            it.payload_first = 8'($urandom_range(0, 7));
            it.payload_size  = 8'($urandom_range(0, 2));
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want, got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
            failures++;
        end
    endfunction

    task automatic offer(input item_t it);
        event_ch.valid          <= 1'b1;
        event_ch.kind           <= it.kind;
        event_ch.packet_id      <= it.packet_id;
        event_ch.packet_type    <= it.packet_type;
        event_ch.payload_size   <= it.payload_size;
        event_ch.payload_first  <= it.payload_first;
        event_ch.payload_second <= it.payload_second;
        do
            @(posedge clk);
        while (event_ch.ready !== 1'b1);
    endtask

    // Sender bursts: back-to-back transactions, then a random gap.
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 10);
        event_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
    endtask

    initial
    begin : main
        int    i;
        int    offered;
        item_t it;
        failures   = 0;
        burst_left = 0;
        drawer     = STATE_RESET;
        rst_n                   <= 1'b0;
        event_ch.valid          <= 1'b0;
        event_ch.kind           <= KIND_PACKET;
        event_ch.packet_id      <= 8'h00;
        event_ch.packet_type    <= 8'h00;
        event_ch.payload_size   <= 8'h00;
        event_ch.payload_first  <= 8'h00;
        event_ch.payload_second <= 8'h00;

        directed = '{
            row(KIND_PACKET, ID_RESET, PTYPE_READ, 8'd1, SUB_STATUS, 8'h00,
                1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0),
            row(KIND_TRAY_EDGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, S_LOADED, ID_RESET, 1'b1, 1'b1, 1'b0),
            // wrong address, then empty payload
            row(KIND_PACKET, 8'h00, PTYPE_WRITE, 8'd1, SUB_DISPENSE, 8'h00,
                1'b1, S_LOADED, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd0, SUB_DISPENSE, 8'h00,
                1'b1, S_LOADED, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd1, SUB_DISPENSE, 8'h00,
                1'b1, ST_DISPENSING, ID_RESET, 1'b0, 1'b1, 1'b0),
            row(KIND_TRAY_EDGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, ST_DISPENSING, ID_RESET, 1'b0, 1'b1, 1'b0),
            row(KIND_BACK_HIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, ST_DISPENSING, ID_RESET, 1'b0, 1'b1, 1'b0),
            row(KIND_FRONT_HIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, S_IDLE_OPEN, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_TRAY_EDGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, S_EMPTY_OPEN, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_READ, 8'd1, SUB_STATUS, 8'h00,
                1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd1, SUB_DISPENSE, 8'h00,
                1'b1, S_EMPTY_OPEN, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd1, SUB_RETRACT, 8'h00,
                1'b1, ST_RETRACTING, ID_RESET, 1'b1, 1'b0, 1'b0),
            row(KIND_FRONT_HIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, ST_RETRACTING, ID_RESET, 1'b1, 1'b0, 1'b0),
            row(KIND_BACK_HIT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b0),
            // LED without its action byte
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd1, SUB_LED, LED_ON,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd2, SUB_LED, LED_ON,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b1),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd2, SUB_LED, 8'hFF,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b1),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd2, SUB_LED, LED_TOGGLE,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd2, SUB_LED, LED_TOGGLE,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b1),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd2, SUB_LED, LED_OFF,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'd1, SUB_CHANGE_ID, 8'hFF,
                1'b1, S_IDLE_CLOSED, ID_RESET, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, ID_RESET, PTYPE_WRITE, 8'hFF, SUB_CHANGE_ID, 8'hFF,
                1'b1, S_IDLE_CLOSED, 8'hFF, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, 8'hFF, PTYPE_WRITE, 8'd2, SUB_UNLOCK, 8'h00,
                1'b1, S_IDLE_CLOSED, 8'hFF, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                1'b1, S_IDLE_CLOSED, 8'hFF, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, 8'hFF, PTYPE_READ, 8'hFF, SUB_STATUS, 8'hFF,
                1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0),
            row(KIND_PACKET, 8'hFF, PTYPE_READ, 8'd1, 8'hFF, 8'h00,
                1'b1, S_IDLE_CLOSED, 8'hFF, 1'b1, 1'b1, 1'b0),
            row(KIND_PACKET, 8'hFF, PTYPE_WRITE, 8'd2, SUB_CHANGE_ID, 8'h00,
                1'b1, S_IDLE_CLOSED, 8'h00, 1'b1, 1'b1, 1'b0)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(directed); i++)
        begin
            if (i > 0)
                pace();
            offer(directed[i].it);
            void'(queue_expected(directed[i].it, directed[i].typed, directed[i].want));
        end

        for (offered = 0; offered < RANDOM_EVENTS; offered++)
        begin
            pace();
            it = random_event();
            offer(it);
            void'(queue_expected(it, 1'b0, STATE_RESET));
        end
        event_ch.valid <= 1'b0;

        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: ready runs, random stalls, blocked stretches, and one long
    // hold-off so the block backs up into its input.
    initial
    begin : receiver
        int segment;
        int mode;
        int len;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        segment = 0;
        forever
        begin
            segment++;
            if (segment == 25)
            begin
                repeat (HOLD_OFF)
                begin
                    @(posedge clk);
                    result_ch.ready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 2);
                len  = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(4, 40);
                repeat (len)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       result_ch.ready <= 1'b1;
                        1:       result_ch.ready <= 1'($urandom_range(0, 1));
                        default: result_ch.ready <= 1'b0;
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: result transaction with nothing expected: byte %02h status %02h",
                         $time, result_ch.reply_byte, result_ch.status_now);
                failures++;
            end
            else
            begin
                want = pending_beats.pop_front();
                check_field("reply_valid", want.reply_valid, result_ch.reply_valid);
                check_field("reply_byte", want.reply_byte, result_ch.reply_byte);
                check_field("last", want.last, result_ch.last);
                check_field("status_now", want.status_now, result_ch.status_now);
                check_field("motor_a", want.motor_a, result_ch.motor_a);
                check_field("motor_b", want.motor_b, result_ch.motor_b);
                check_field("led_on", want.led_on, result_ch.led_on);
                check_field("current_id", want.current_id, result_ch.current_id);
            end
        end
    end

    initial
    begin : watchdog
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("%0t: timeout, %0d result transactions still expected",
                 $time, pending_beats.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
